// ----- hdl/plc_pkg.sv -----
// Package for the positional list with cursor: sizes, command and status codes.
`default_nettype none

package plc_pkg;

	localparam int CAPACITY = 64;
	localparam int DATA_W   = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = 7;
	localparam int ACT_W    = 4;
	localparam int STAT_W   = 2;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 112;

	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	typedef enum logic [ACT_W-1:0] {
		ACT_APPEND       = 4'd0,
		ACT_REMOVE_AT    = 4'd1,
		ACT_REMOVE_FRONT = 4'd2,
		ACT_REMOVE_BACK  = 4'd3,
		ACT_FORWARD      = 4'd4,
		ACT_BACKWARD     = 4'd5,
		ACT_SELECT       = 4'd6,
		ACT_CLEAR        = 4'd7,
		ACT_QUERY        = 4'd8
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_RANGE = 2'd2,
		STAT_FULL  = 2'd3
	} status_t;

endpackage

`default_nettype wire

// ----- hdl/positional_list_with_cursor.sv -----
// Top level of the positional list with cursor: command decode, entry memory, shift engine.
`default_nettype none

// Ordered list of up to 64 entries of 32 bits, kept packed from position 1 in a
// single-port-read, single-port-write synchronous memory, with a one-based cursor.
// One command is taken at a time and gives one result. For a command that does not
// remove an entry ahead of the last, the state is updated at the transfer, then three
// memory reads (cursor, front, back) go through the one read port in S_RD_CUR,
// S_RD_FRONT and S_RD_BACK, and S_DONE loads the result once the output register is
// free; the next command can be taken after that. A removal at position p of a list
// of n entries first moves the n-p following entries down one place, one entry per
// cycle through the read-then-write path. The result sits in an output register, so
// the next command is taken while it waits. After reset the block is ready at once;
// data read from entries beyond the count is replaced by zero in the result.
module positional_list_with_cursor
	import plc_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// command side
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// [6:0] position, [38:7] entry_data, [39] zero
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	// [3:0] action
	input  wire logic [ACT_W-1:0]       s_tuser,
	// result side
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// [1:0] status, [8:2] entry_count, [15:9] cursor_position,
	// [47:16] current_data, [79:48] front_data, [111:80] back_data
	output logic [OUT_TDATA_W-1:0]      m_tdata
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SHIFT,
		S_RD_CUR,
		S_RD_FRONT,
		S_RD_BACK,
		S_DONE
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   len_q;
	logic [CNT_W-1:0]   cur_q;
	status_t            status_q;
	logic [CNT_W-1:0]   k_q;
	logic [CNT_W-1:0]   end_q;
	logic               wr_v_s1;
	logic [IDX_W-1:0]   wr_a_s1;
	logic [DATA_W-1:0]  cur_data_q;
	logic [DATA_W-1:0]  front_data_q;
	logic               m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	logic [DATA_W-1:0]  mem_q [CAPACITY];
	logic [DATA_W-1:0]  rd_q;

	logic [CNT_W-1:0]   in_pos;
	logic [DATA_W-1:0]  in_data;
	logic               acc;

	logic [CNT_W-1:0]   nxt_len;
	logic [CNT_W-1:0]   nxt_cur;
	status_t            nxt_status;
	logic               app_we;
	logic               shift_go;
	logic [CNT_W-1:0]   rpos;
	logic               is_remove;

	logic               rd_en;
	logic [IDX_W-1:0]   rd_a;
	logic               mem_we;
	logic [IDX_W-1:0]   mem_wa;
	logic [DATA_W-1:0]  mem_wd;
	logic               out_free;

	assign in_pos   = s_tdata[CNT_W-1:0];
	assign in_data  = s_tdata[CNT_W+DATA_W-1:CNT_W];
	assign s_tready = (state_q == S_IDLE);
	assign acc      = s_tvalid & s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign out_free = !m_tvalid_q || m_tready;

	// command decode against the current count and cursor
	always_comb begin
		nxt_len    = len_q;
		nxt_cur    = cur_q;
		nxt_status = STAT_OK;
		app_we     = 1'b0;
		shift_go   = 1'b0;
		is_remove  = 1'b0;
		rpos       = len_q;
		unique case (s_tuser)
			ACT_APPEND: begin
				if (len_q >= CAP_CNT) begin
					nxt_status = STAT_FULL;
				end else begin
					app_we  = 1'b1;
					nxt_len = len_q + CNT_W'(1);
					if (len_q == '0) nxt_cur = CNT_W'(1);
				end
			end
			ACT_REMOVE_AT: begin
				is_remove = 1'b1;
				rpos      = in_pos;
			end
			ACT_REMOVE_FRONT: begin
				is_remove = 1'b1;
				rpos      = CNT_W'(1);
			end
			ACT_REMOVE_BACK: begin
				is_remove = 1'b1;
				rpos      = len_q;
			end
			ACT_FORWARD: begin
				if (len_q == '0) nxt_status = STAT_EMPTY;
				else if (cur_q >= CNT_W'(1) && cur_q < len_q) nxt_cur = cur_q + CNT_W'(1);
				else nxt_cur = CNT_W'(1);
			end
			ACT_BACKWARD: begin
				if (len_q == '0) nxt_status = STAT_EMPTY;
				else if (cur_q > CNT_W'(1) && cur_q <= len_q) nxt_cur = cur_q - CNT_W'(1);
				else nxt_cur = len_q;
			end
			ACT_SELECT: begin
				if (len_q == '0) nxt_status = STAT_EMPTY;
				else if (in_pos == '0 || in_pos > len_q) nxt_status = STAT_RANGE;
				else nxt_cur = in_pos;
			end
			ACT_CLEAR: begin
				nxt_len = '0;
				nxt_cur = '0;
			end
			default: begin
			end
		endcase

		// removal shared by the three remove commands
		if (is_remove) begin
			if (len_q == '0) begin
				nxt_status = STAT_EMPTY;
			end else if (rpos == '0 || rpos > len_q) begin
				nxt_status = STAT_RANGE;
			end else begin
				nxt_len  = len_q - CNT_W'(1);
				shift_go = (rpos < len_q);
				if (rpos < cur_q) nxt_cur = cur_q - CNT_W'(1);
				else if (rpos == cur_q && rpos == len_q) nxt_cur = cur_q - CNT_W'(1);
				if (len_q == CNT_W'(1)) nxt_cur = '0;
			end
		end
	end

	// read port address: shift source, then cursor, front and back
	always_comb begin
		rd_en = 1'b0;
		rd_a  = '0;
		unique case (state_q)
			S_SHIFT: begin
				rd_en = (k_q < end_q);
				rd_a  = k_q[IDX_W-1:0];
			end
			S_RD_CUR: begin
				rd_en = 1'b1;
				rd_a  = IDX_W'(cur_q - CNT_W'(1));
			end
			S_RD_FRONT: begin
				rd_en = 1'b1;
				rd_a  = '0;
			end
			S_RD_BACK: begin
				rd_en = 1'b1;
				rd_a  = IDX_W'(len_q - CNT_W'(1));
			end
			default: begin
			end
		endcase
	end

	// write port: append at the transfer, or shifted entry one place down
	assign mem_we = (acc && app_we) || wr_v_s1;
	assign mem_wa = wr_v_s1 ? wr_a_s1 : len_q[IDX_W-1:0];
	assign mem_wd = wr_v_s1 ? rd_q : in_data;

	// entry memory
	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_wa] <= mem_wd;
		if (rd_en) rd_q <= mem_q[rd_a];
	end

	// sequencer, list state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			len_q        <= '0;
			cur_q        <= '0;
			status_q     <= STAT_OK;
			k_q          <= '0;
			end_q        <= '0;
			wr_v_s1      <= 1'b0;
			wr_a_s1      <= '0;
			cur_data_q   <= '0;
			front_data_q <= '0;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
		end else begin
			// result taken; S_DONE loads the next one itself
			if (m_tvalid_q && m_tready && state_q != S_DONE) m_tvalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						len_q    <= nxt_len;
						cur_q    <= nxt_cur;
						status_q <= nxt_status;
						k_q      <= rpos;
						end_q    <= len_q;
						state_q  <= shift_go ? S_SHIFT : S_RD_CUR;
					end
				end
				S_SHIFT: begin
					if (k_q < end_q) begin
						k_q     <= k_q + CNT_W'(1);
						wr_v_s1 <= 1'b1;
						wr_a_s1 <= IDX_W'(k_q - CNT_W'(1));
					end else begin
						wr_v_s1 <= 1'b0;
						if (!wr_v_s1) state_q <= S_RD_CUR;
					end
				end
				S_RD_CUR: begin
					state_q <= S_RD_FRONT;
				end
				S_RD_FRONT: begin
					cur_data_q <= (cur_q == '0) ? '0 : rd_q;
					state_q    <= S_RD_BACK;
				end
				S_RD_BACK: begin
					front_data_q <= (len_q == '0) ? '0 : rd_q;
					state_q      <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {((len_q == '0) ? DATA_W'(0) : rd_q), front_data_q,
							cur_data_q, cur_q, len_q, status_q};
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// the cursor stays inside the list
	a_cur_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q <= len_q)
		else $error("cursor beyond entry count");

	// empty list and zero cursor go together
	a_cur_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(len_q == '0) == (cur_q == '0))
		else $error("cursor and count disagree on empty list");

	// no shifted write is still in flight when a command is taken
	a_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !wr_v_s1)
		else $error("command taken with shift write pending");

	// a removal that shifts entries shortens the list by exactly one
	a_remove_len: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && shift_go) |=> (len_q == $past(len_q) - CNT_W'(1)))
		else $error("removal changed count wrongly");

endmodule

`default_nettype wire
